FILE: src/dvc_pkg.sv
`default_nettype none

package dvc_pkg;

  localparam int NUM_FIELDS = 4;
  localparam int FIELD_W    = 30;
  localparam int IDX_W      = (NUM_FIELDS > 1) ? $clog2(NUM_FIELDS) : 1;

  localparam logic [FIELD_W-1:0] FIELD_LIMIT = FIELD_W'(100000000);

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LOW_V = 8'h76;
  localparam logic [7:0] CH_UP_V  = 8'h56;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [2:0] {
    PS_PARSING = 3'b001,
    PS_OK      = 3'b010,
    PS_BAD     = 3'b100
  } parse_status_e;

  typedef logic [FIELD_W-1:0]       field_t;
  typedef field_t [NUM_FIELDS-1:0]  field_vec_t;

  // one character word as it enters the parser
  typedef struct packed {
    logic       last;
    logic       is_current;
    logic [7:0] ch;
  } in_word_t;

  // verdict, newer in the lowest bit
  typedef struct packed {
    logic current_valid;
    logic latest_valid;
    logic newer;
  } res_t;

endpackage

`default_nettype wire

FILE: src/dvc_in_stage.sv
`default_nettype none

module dvc_in_stage (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              valid_i,
  output logic             ready_o,
  input  wire dvc_pkg::in_word_t word_i,
  input  wire              advance_i,
  output logic             valid_o,
  output dvc_pkg::in_word_t word_o
);
  import dvc_pkg::*;

  logic     valid_q, valid_d;
  in_word_t word_q;

  // take a new word when empty or when the held one moves on this cycle
  assign ready_o = !valid_q || advance_i;

  always_comb begin
    valid_d = valid_q;
    if (ready_o) begin
      valid_d = valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      word_q <= word_i;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

`default_nettype wire

FILE: src/dvc_core.sv
`default_nettype none

module dvc_core (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              advance_i,
  input  wire dvc_pkg::in_word_t word_i,
  output logic             emit_o,
  output dvc_pkg::res_t    res_o
);
  import dvc_pkg::*;

  field_vec_t    lat_q, lat_d;
  field_vec_t    cur_q, cur_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic          seen_q, seen_d;
  parse_status_e status_q, status_d;
  logic          start_q, start_d;
  logic          lat_ok_q, lat_ok_d;

  field_vec_t    fld_base, fld_new;
  field_t        fld_val, fld_mul;
  logic [IDX_W-1:0] idx_n;
  logic          seen_n;
  parse_status_e status_n;
  logic          is_digit, is_term, skip_v;
  logic          cur_ok, newer;

  assign is_digit = (word_i.ch >= CH_ZERO) && (word_i.ch <= CH_NINE);
  assign is_term  = (word_i.ch == CH_NUL) || (word_i.ch == CH_MINUS) ||
                    (word_i.ch == CH_PLUS);
  assign skip_v   = start_q && ((word_i.ch == CH_LOW_V) || (word_i.ch == CH_UP_V));

  // parse one character against the selected field store
  always_comb begin
    fld_base = word_i.is_current ? cur_q : lat_q;
    if (start_q) begin
      fld_base = '0;
    end
    fld_new  = fld_base;
    fld_val  = fld_base[idx_q];
    fld_mul  = (fld_val << 3) + (fld_val << 1);
    idx_n    = idx_q;
    seen_n   = seen_q;
    status_n = status_q;
    if (status_q == PS_PARSING && !skip_v) begin
      if (is_digit) begin
        if (fld_val > FIELD_LIMIT) begin
          status_n = PS_BAD;
        end else begin
          fld_new[idx_q] = fld_mul + FIELD_W'(word_i.ch[3:0]);
          seen_n = 1'b1;
        end
      end else if (is_term) begin
        status_n = seen_q ? PS_OK : PS_BAD;
      end else if (word_i.ch == CH_DOT) begin
        if (!seen_q || idx_q == IDX_W'(NUM_FIELDS - 1)) begin
          status_n = PS_BAD;
        end else begin
          idx_n  = idx_q + IDX_W'(1);
          seen_n = 1'b0;
        end
      end else begin
        status_n = PS_BAD;
      end
    end
    // end of string closes a field still open
    if (word_i.last && status_n == PS_PARSING) begin
      status_n = seen_n ? PS_OK : PS_BAD;
    end
  end

  // most significant field first: lowest differing index decides
  always_comb begin
    newer = 1'b0;
    for (int i = NUM_FIELDS - 1; i >= 0; i--) begin
      if (lat_q[i] != fld_new[i]) begin
        newer = lat_q[i] > fld_new[i];
      end
    end
    cur_ok = (status_n == PS_OK);
  end

  assign emit_o            = advance_i && word_i.last && word_i.is_current;
  assign res_o.newer         = newer && lat_ok_q && cur_ok;
  assign res_o.latest_valid  = lat_ok_q;
  assign res_o.current_valid = cur_ok;

  always_comb begin
    lat_d    = lat_q;
    cur_d    = cur_q;
    idx_d    = idx_q;
    seen_d   = seen_q;
    status_d = status_q;
    start_d  = start_q;
    lat_ok_d = lat_ok_q;
    if (advance_i) begin
      if (word_i.last && word_i.is_current) begin
        // verdict out, drop everything
        lat_d    = '0;
        cur_d    = '0;
        idx_d    = '0;
        seen_d   = 1'b0;
        status_d = PS_PARSING;
        start_d  = 1'b1;
        lat_ok_d = 1'b0;
      end else if (word_i.last) begin
        lat_d    = fld_new;
        lat_ok_d = (status_n == PS_OK);
        idx_d    = '0;
        seen_d   = 1'b0;
        status_d = PS_PARSING;
        start_d  = 1'b1;
      end else begin
        if (word_i.is_current) begin
          cur_d = fld_new;
        end else begin
          lat_d = fld_new;
          if (start_q) begin
            lat_ok_d = 1'b0;
          end
        end
        idx_d    = idx_n;
        seen_d   = seen_n;
        status_d = status_n;
        start_d  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lat_q    <= '0;
      cur_q    <= '0;
      idx_q    <= '0;
      seen_q   <= 1'b0;
      status_q <= PS_PARSING;
      start_q  <= 1'b1;
      lat_ok_q <= 1'b0;
    end else begin
      lat_q    <= lat_d;
      cur_q    <= cur_d;
      idx_q    <= idx_d;
      seen_q   <= seen_d;
      status_q <= status_d;
      start_q  <= start_d;
      lat_ok_q <= lat_ok_d;
    end
  end

endmodule

`default_nettype wire

FILE: src/dvc_out_stage.sv
`default_nettype none

module dvc_out_stage (
  input  wire           clk_i,
  input  wire           rst_ni,
  input  wire           load_i,
  input  wire dvc_pkg::res_t res_i,
  output logic          free_o,
  output logic          valid_o,
  input  wire           ready_i,
  output dvc_pkg::res_t res_o
);
  import dvc_pkg::*;

  logic valid_q, valid_d;
  res_t res_q;

  // slot is free when empty or drained this cycle
  assign free_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

`default_nettype wire

FILE: src/dotted_version_compare.sv
// Channel  Dir  Word                            Per word
// s_axis   in   tdata=ch, tuser=is_current      one character of a version string
//               tlast=last                      final character of that string
// m_axis   out  tdata={00000,cur_v,lat_v,newer} one verdict per current string
//
// One character per cycle while the output is not stalled. From input to verdict
// a word passes an input register, then the parser step into the output register.
// The parser state and both field stores update in that single step.
// Reset clears all parser state and field stores at once.
// A stalled output holds the parser and the input register; while
// m_axis_tready is high, s_axis_tready is high.
`default_nettype none

module dotted_version_compare (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        s_axis_tvalid,
  output logic       s_axis_tready,
  input  wire  [7:0] s_axis_tdata,   // [7:0] ch
  input  wire        s_axis_tuser,   // [0] is_current
  input  wire        s_axis_tlast,
  output logic       m_axis_tvalid,
  input  wire        m_axis_tready,
  output logic [7:0] m_axis_tdata    // [0] newer, [1] latest_valid, [2] current_valid
);
  import dvc_pkg::*;

  in_word_t in_word, word;
  logic     word_valid, advance, emit, out_free;
  res_t     res, res_out;

  assign in_word.ch         = s_axis_tdata;
  assign in_word.is_current = s_axis_tuser;
  assign in_word.last       = s_axis_tlast;

  assign advance = word_valid && out_free;

  dvc_in_stage u_in (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s_axis_tvalid),
    .ready_o   (s_axis_tready),
    .word_i    (in_word),
    .advance_i (advance),
    .valid_o   (word_valid),
    .word_o    (word)
  );

  dvc_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .word_i    (word),
    .emit_o    (emit),
    .res_o     (res)
  );

  dvc_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (emit),
    .res_i   (res),
    .free_o  (out_free),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .res_o   (res_out)
  );

  assign m_axis_tdata = {5'b0, res_out};

endmodule

`default_nettype wire

FILE: src/dvc_checker.sv
`default_nettype none

module dvc_checker (
  input wire       clk_i,
  input wire       rst_ni,
  input wire       s_axis_tvalid,
  input wire       s_axis_tready,
  input wire [7:0] s_axis_tdata,
  input wire       s_axis_tuser,
  input wire       s_axis_tlast,
  input wire       m_axis_tvalid,
  input wire       m_axis_tready,
  input wire [7:0] m_axis_tdata
);

  // a stalled word stays up
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("output word changed while stalled");

  // newer only when both strings parsed
  a_newer_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[1] && m_axis_tdata[2])
    else $error("newer set without both strings valid");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[7:3] == 5'b0)
    else $error("padding bits not zero");

  // a draining output never blocks the input side
  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled while output ready");

endmodule

bind dotted_version_compare dvc_checker u_dvc_checker (.*);

`default_nettype wire
